// ----- hdl/msr_pkg.sv -----
// Package for the motor speed step regulator: types, codes and constants.
`default_nettype none
package msr_pkg;

  // Item kinds carried in tuser
  typedef enum logic {
    OP_SAMPLE     = 1'b0,
    OP_SET_TARGET = 1'b1
  } msr_op_e;

  // Register word index (byte address bit 2)
  typedef enum logic {
    REG_POWER_MIN   = 1'b0,
    REG_POWER_LIMIT = 1'b1
  } msr_reg_e;

  // Regulator state
  typedef struct packed {
    logic [15:0] target;
    logic [7:0]  power;
    logic [1:0]  hold;
    logic [15:0] speed;
  } msr_state_t;

  // Reset values
  localparam logic [7:0]  POWER_MIN_RST   = 8'd20;
  localparam logic [7:0]  POWER_LIMIT_RST = 8'd85;
  localparam logic [7:0]  POWER_IDLE      = 8'd1;

  // Error thresholds on the wrapped difference
  localparam logic signed [15:0] DEAD_LOW  = -16'sd5;
  localparam logic signed [15:0] DEAD_HIGH = 16'sd3;
  localparam logic signed [15:0] BIG_UP    = 16'sd20;
  localparam logic signed [15:0] BIG_DOWN  = -16'sd20;
  localparam logic signed [15:0] HUGE_UP   = 16'sd30;
  localparam logic signed [15:0] HUGE_DOWN = -16'sd50;

  // Power steps
  localparam logic signed [9:0] STEP_DOWN_HUGE = -10'sd15;
  localparam logic signed [9:0] STEP_DOWN_BIG  = -10'sd7;
  localparam logic signed [9:0] STEP_DOWN      = -10'sd3;
  localparam logic signed [9:0] STEP_UP_HUGE   = 10'sd6;
  localparam logic signed [9:0] STEP_UP_BIG    = 10'sd2;
  localparam logic signed [9:0] STEP_UP        = 10'sd1;

  localparam logic [1:0]  HOLD_LEN   = 2'd3;
  localparam logic [15:0] MIN_TARGET = 16'd2;

endpackage
`default_nettype wire

// ----- hdl/msr_step.sv -----
// Next-state logic of the regulator for one item.
`default_nettype none
module msr_step
  import msr_pkg::*;
(
  input  msr_state_t  state_i,
  input  msr_op_e     opcode_i,
  input  logic [15:0] tach_count_i,
  input  logic [15:0] target_pulses_i,
  input  logic [7:0]  requested_power_i,
  input  logic [7:0]  power_min_i,
  input  logic [7:0]  power_limit_i,
  output msr_state_t  state_o
);

  logic signed [15:0] diff;
  logic               dead_band;
  logic               big_err;
  logic signed [9:0]  step;
  logic signed [9:0]  pwr_raw;
  logic signed [9:0]  pwr_lo;
  logic [7:0]         pwr_clamped;

  // Wrapped error between target and fresh count
  assign diff      = signed'(state_i.target - tach_count_i);
  assign dead_band = (diff > DEAD_LOW) && (diff < DEAD_HIGH);
  assign big_err   = (diff < BIG_DOWN) || (diff > BIG_UP);

  // Pick the step: down faster than up
  always_comb begin
    if (diff < HUGE_DOWN) begin
      step = STEP_DOWN_HUGE;
    end else if (diff < BIG_DOWN) begin
      step = STEP_DOWN_BIG;
    end else if (diff < 16'sd0) begin
      step = STEP_DOWN;
    end else if (diff > HUGE_UP) begin
      step = STEP_UP_HUGE;
    end else if (diff > BIG_UP) begin
      step = STEP_UP_BIG;
    end else begin
      step = STEP_UP;
    end
  end

  // Step and clamp: lower bound first, upper bound last
  assign pwr_raw = signed'({2'b00, state_i.power}) + step;
  assign pwr_lo  = (pwr_raw < signed'({2'b00, power_min_i})) ?
                   signed'({2'b00, power_min_i}) : pwr_raw;
  assign pwr_clamped = (pwr_lo > signed'({2'b00, power_limit_i})) ?
                       power_limit_i : pwr_lo[7:0];

  // Apply the item
  always_comb begin
    state_o = state_i;
    case (opcode_i)
      OP_SET_TARGET: begin
        if (target_pulses_i != state_i.target) begin
          if ((target_pulses_i < MIN_TARGET) || (requested_power_i == 8'd0)) begin
            state_o.power = POWER_IDLE;
          end
          state_o.target = target_pulses_i;
        end
      end
      OP_SAMPLE: begin
        state_o.speed = tach_count_i;
        if (state_i.target == 16'd0) begin
          state_o.power = POWER_IDLE;
        end else if (state_i.hold != 2'd0) begin
          state_o.hold = state_i.hold - 2'd1;
        end else if (!dead_band) begin
          state_o.power = pwr_clamped;
          if (big_err) begin
            state_o.hold = HOLD_LEN;
          end
        end
      end
      default: state_o = state_i;
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/motor_speed_step_regulator.sv -----
// Top level of the motor speed step regulator: stream ports, registers, APB port.
//
//  Channel   Dir   Handshake          Payload
//  s_*       in    s_tvalid/s_tready  tdata: tach_count, target_pulses, requested_power
//                                      tuser: opcode
//  m_*       out   m_tvalid/m_tready  tdata: motor_power, measured_speed
//  apb       in    psel/penable       power_min (0x0), power_limit (0x4)
//
// One item per cycle unless the result stalls; input register, then result register.
// The regulator state and the result register update together on each transfer from the
// input register, so each item sees the state left by the item before it.
// Reset clears valid flags and state (power idle), sets power bounds; no clearing pass.
// A stalled result holds the input register; the input side keeps taking items while
// the input register is free or drains in the same cycle.
`default_nettype none
module motor_speed_step_regulator
  import msr_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item stream in
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [15:0] tach_count, [31:16] target_pulses,
                                 // [39:32] requested_power
  input  logic        s_tuser,   // [0] opcode
  // Result stream out
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // [7:0] motor_power, [23:8] measured_speed
  // Configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic        in_valid_q;
  msr_op_e     in_op_q;
  logic [15:0] in_tach_q;
  logic [15:0] in_pulses_q;
  logic [7:0]  in_req_q;
  logic        out_valid_q;
  logic [7:0]  out_power_q;
  logic [15:0] out_speed_q;
  logic [7:0]  power_min_q;
  logic [7:0]  power_limit_q;
  msr_state_t  state_q;
  msr_state_t  state_d;
  msr_reg_e    reg_sel;
  logic        advance;
  logic        cfg_wr;

  // Transfer from the input register into the result register
  assign advance  = in_valid_q && (!out_valid_q || m_tready);
  assign s_tready = !in_valid_q || advance;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_tready) begin
      in_valid_q <= s_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_tvalid && s_tready) begin
      in_op_q     <= msr_op_e'(s_tuser);
      in_tach_q   <= s_tdata[15:0];
      in_pulses_q <= s_tdata[31:16];
      in_req_q    <= s_tdata[39:32];
    end
  end

  // Next-state logic
  msr_step u_step (
    .state_i           (state_q),
    .opcode_i          (in_op_q),
    .tach_count_i      (in_tach_q),
    .target_pulses_i   (in_pulses_q),
    .requested_power_i (in_req_q),
    .power_min_i       (power_min_q),
    .power_limit_i     (power_limit_q),
    .state_o           (state_d)
  );

  // Regulator state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.target <= 16'd0;
      state_q.power  <= POWER_IDLE;
      state_q.hold   <= 2'd0;
      state_q.speed  <= 16'd0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_power_q <= state_d.power;
      out_speed_q <= state_d.speed;
    end
  end

  assign m_tvalid = out_valid_q;
  assign m_tdata  = {out_speed_q, out_power_q};

  // Configuration registers, decoded on the word index
  assign pready  = 1'b1;
  assign reg_sel = msr_reg_e'(paddr[2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_min_q   <= POWER_MIN_RST;
      power_limit_q <= POWER_LIMIT_RST;
    end else if (cfg_wr) begin
      case (reg_sel)
        REG_POWER_MIN:   power_min_q   <= pwdata[7:0];
        REG_POWER_LIMIT: power_limit_q <= pwdata[7:0];
        default: begin
        end
      endcase
    end
  end

  // Read back; byte lanes in the low address bits are ignored
  always_comb begin
    case (reg_sel)
      REG_POWER_MIN:   prdata = {24'd0, power_min_q};
      REG_POWER_LIMIT: prdata = {24'd0, power_limit_q};
      default:         prdata = 32'd0;
    endcase
    if (!psel) begin
      prdata = 32'd0;
    end
  end

  // Result register tracks the state it was loaded from
  a_out_matches_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_power_q == state_q.power) && (out_speed_q == state_q.speed))
    else $error("result register differs from regulator state");

  // Input is stalled only behind a held result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_tready |-> in_valid_q && out_valid_q && !m_tready)
    else $error("input stalled without a held result");

  // Sample with zero target idles the motor
  a_zero_target: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_op_q == OP_SAMPLE) && (state_q.target == 16'd0)
    |=> state_q.power == POWER_IDLE)
    else $error("zero target did not idle the motor");

  // Hold counts down one per sample
  a_hold_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && (in_op_q == OP_SAMPLE) && (state_q.target != 16'd0) && (state_q.hold != 2'd0)
    |=> (state_q.hold == $past(state_q.hold) - 2'd1) && $stable(state_q.power))
    else $error("hold count did not count down");

endmodule
`default_nettype wire
